FILE: rtl/shwid_pkg.sv
// ----------------------------------------------------------------------------
// shwid_pkg
// Shared widths, result kinds and the per-string state record for the
// string hash with array-index detection.
// ----------------------------------------------------------------------------
package shwid_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned KIND_W = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REGULAR      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INDEX        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MAX_UNSIGNED = 2'd2;

  localparam logic [HASH_W-1:0] ALL_ONES    = {HASH_W{1'b1}};
  localparam logic [UNIT_W-1:0] DIGIT_ZERO  = 16'h0030;
  localparam logic [UNIT_W-1:0] DIGIT_MAX   = 16'd9;

  // Running state of the string being taken
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [HASH_W-1:0] number;
    logic              still_numeric;
    logic              at_first;
    logic              lead_zero;
  } str_state_t;

  localparam str_state_t STATE_CLEAR = '{
    hash:          ALL_ONES,
    number:        '0,
    still_numeric: 1'b1,
    at_first:      1'b1,
    lead_zero:     1'b0
  };

  // Result of one step
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [KIND_W-1:0] kind;
  } step_res_t;

endpackage

FILE: rtl/shwid_if.sv
// ----------------------------------------------------------------------------
// shwid_in_if / shwid_out_if
// Valid/ready channels for code units in and hash results out.
// ----------------------------------------------------------------------------
interface shwid_in_if;
  logic                      valid;
  logic                      ready;
  logic [shwid_pkg::UNIT_W-1:0] code_unit;
  logic                      last_unit;
  logic                      empty_string;

  modport source (output valid, code_unit, last_unit, empty_string, input ready);
  modport sink   (input valid, code_unit, last_unit, empty_string, output ready);
endinterface

interface shwid_out_if;
  logic                      valid;
  logic                      ready;
  logic [shwid_pkg::HASH_W-1:0] hash_value;
  logic [shwid_pkg::KIND_W-1:0] string_kind;

  modport source (output valid, hash_value, string_kind, input ready);
  modport sink   (input valid, hash_value, string_kind, output ready);
endinterface

FILE: rtl/shwid_step.sv
// ----------------------------------------------------------------------------
// shwid_step
// One code unit of work: polynomial hash update, decimal parse update and,
// on the final unit or an empty string, the result selection.
// ----------------------------------------------------------------------------
module shwid_step (
  input  shwid_pkg::str_state_t                state_i,
  input  logic [shwid_pkg::UNIT_W-1:0]         code_unit_i,
  input  logic                                 last_unit_i,
  input  logic                                 empty_string_i,
  output shwid_pkg::str_state_t                state_o,
  output shwid_pkg::step_res_t                 res_o
);
  import shwid_pkg::*;

  logic [HASH_W-1:0] hash_upd;
  logic [UNIT_W-1:0] digit;
  logic              is_digit;
  logic [HASH_W+3:0] num_ext;
  logic              num_ovf;
  str_state_t        upd;

  // h*31 + unit as (h<<5) - h + unit, mod 2^32
  assign hash_upd = (state_i.hash << 5) - state_i.hash + {{(HASH_W-UNIT_W){1'b0}}, code_unit_i};

  assign digit    = code_unit_i - DIGIT_ZERO;
  assign is_digit = (digit <= DIGIT_MAX);

  // n*10 + d as (n<<3) + (n<<1) + d, kept wide for an exact overflow test
  assign num_ext = ({4'b0000, state_i.number} << 3) + ({4'b0000, state_i.number} << 1)
                 + {{(HASH_W+4-UNIT_W){1'b0}}, digit};
  assign num_ovf = |num_ext[HASH_W+3:HASH_W];

  // Advance the parse state
  always_comb begin
    upd          = state_i;
    upd.hash     = hash_upd;
    upd.at_first = 1'b0;
    if (!is_digit) begin
      upd.still_numeric = 1'b0;
    end else if (state_i.at_first) begin
      upd.number    = num_ext[HASH_W-1:0];
      upd.lead_zero = (digit == '0);
    end else if (state_i.lead_zero) begin
      upd.still_numeric = 1'b0;
    end else if (state_i.still_numeric) begin
      if (num_ovf) begin
        upd.still_numeric = 1'b0;
      end else begin
        upd.number = num_ext[HASH_W-1:0];
      end
    end
  end

  // Pick the result and clear the state at end of string
  always_comb begin
    res_o   = '0;
    state_o = upd;
    if (empty_string_i) begin
      res_o.valid = 1'b1;
      res_o.hash  = ALL_ONES;
      res_o.kind  = KIND_REGULAR;
      state_o     = STATE_CLEAR;
    end else if (last_unit_i) begin
      res_o.valid = 1'b1;
      if (upd.still_numeric) begin
        res_o.hash = upd.number;
        res_o.kind = (upd.number == ALL_ONES) ? KIND_MAX_UNSIGNED : KIND_INDEX;
      end else begin
        res_o.hash = upd.hash;
        res_o.kind = KIND_REGULAR;
      end
      state_o = STATE_CLEAR;
    end
  end

endmodule

FILE: rtl/shwid_out_stage.sv
// ----------------------------------------------------------------------------
// shwid_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module shwid_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  shwid_pkg::step_res_t res_i,
  output logic                 can_load_o,
  shwid_out_if.source          out_o
);
  import shwid_pkg::*;

  logic              valid_q, valid_d;
  logic [HASH_W-1:0] hash_q;
  logic [KIND_W-1:0] kind_q;

  assign can_load_o = !valid_q || out_o.ready;

  // Set on load, drop when taken
  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hash_q <= res_i.hash;
      kind_q <= res_i.kind;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.hash_value  = hash_q;
  assign out_o.string_kind = kind_q;

  // A max-unsigned result always carries the all-ones value
  a_max_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (kind_q == KIND_MAX_UNSIGNED) |-> hash_q == ALL_ONES)
    else $error("max-unsigned kind without all-ones value");

  // Loading is only done into a free or draining register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("result register overwritten");

  // Never a kind code outside the defined set
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (kind_q == KIND_REGULAR) || (kind_q == KIND_INDEX)
             || (kind_q == KIND_MAX_UNSIGNED))
    else $error("undefined kind code");

endmodule

FILE: rtl/string_hash_with_index_detect.sv
// ----------------------------------------------------------------------------
// string_hash_with_index_detect
// Polynomial string hash (x31) with canonical decimal array-index detection.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_i    | in  | valid/ready  | code_unit[15:0], last_unit, empty_string
//  out_o   | out | valid/ready  | hash_value[31:0], string_kind[1:0]
//
//  One code unit per cycle while no result stalls; a result passes the input
//  register, then the result register, after its final unit is accepted.
//  The hash and parse update is one combinational step on the running state.
//  Reset clears the running state to a fresh string and empties both stages.
//  A stalled result holds back only a unit that ends a string and those behind it.
// ----------------------------------------------------------------------------
module string_hash_with_index_detect (
  input  logic        clk_i,
  input  logic        rst_ni,
  shwid_in_if.sink    in_i,
  shwid_out_if.source out_o
);
  import shwid_pkg::*;

  logic              in_valid_q;
  logic [UNIT_W-1:0] unit_q;
  logic              last_q;
  logic              empty_q;
  str_state_t        state_q, state_d;
  step_res_t         res;
  logic              can_load;
  logic              advance;
  logic              in_acc;

  // Process the registered unit when its result (if any) has room
  assign advance  = in_valid_q && (!res.valid || can_load);
  assign in_i.ready = !in_valid_q || advance;
  assign in_acc   = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      unit_q  <= in_i.code_unit;
      last_q  <= in_i.last_unit;
      empty_q <= in_i.empty_string;
    end
  end

  shwid_step u_step (
    .state_i        (state_q),
    .code_unit_i    (unit_q),
    .last_unit_i    (last_q),
    .empty_string_i (empty_q),
    .state_o        (state_d),
    .res_o          (res)
  );

  // Running string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_CLEAR;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  shwid_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res.valid),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

  // State is fresh after every emitted result
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.valid |=> state_q == STATE_CLEAR)
    else $error("state not cleared after result");

  // A fresh string has the initial hash and no number
  a_fresh_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.at_first |-> (state_q.hash == ALL_ONES) && (state_q.number == '0))
    else $error("fresh string state corrupted");

  // A held unit stays in the input register until processed
  a_hold_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(unit_q) && $stable(state_q))
    else $error("held unit lost");

endmodule
